// File: hw/rtl/arm_data_processing_alu_assert.svh
// ----------------------------------------------------------------------------
// ARM data-processing ALU assertion macros
// Shared property forms for the checker of the data-processing ALU.
// ----------------------------------------------------------------------------
`ifndef ARM_DATA_PROCESSING_ALU_ASSERT_SVH
`define ARM_DATA_PROCESSING_ALU_ASSERT_SVH

// Same-cycle implication, skipped while rst is high.
`define ADPALU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while rst is high.
`define ADPALU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/adpalu_pkg.sv
// ----------------------------------------------------------------------------
// ARM data-processing ALU package
// Field widths, opcode and shift codes, and the operand-2 barrel shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adpalu_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned FLAGS_W     = 4;
   localparam int unsigned REG_W       = 4;
   // instr, rn_value, rm_data, rs_data, flags_in, padded to whole bytes
   localparam int unsigned REQ_FIELD_W = 4 * WORD_W + FLAGS_W;
   localparam int unsigned REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   // result, write_enable, dest_reg, flags_out, flags_written, pc_flush, restore_psr
   localparam int unsigned RSP_FIELD_W = WORD_W + 1 + REG_W + FLAGS_W + 3;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [REG_W-1:0] PC_REG = 4'hf;

   typedef enum logic [3:0] {
      OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
      OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
      OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'ha, OP_CMN = 4'hb,
      OP_ORR = 4'hc, OP_MOV = 4'hd, OP_BIC = 4'he, OP_MVN = 4'hf
   } opcode_type;

   typedef enum logic [1:0] {
      SH_LSL = 2'd0, SH_LSR = 2'd1, SH_ASR = 2'd2, SH_ROR = 2'd3
   } shift_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              carry;
   } shift_res_type;

   typedef struct packed {
      logic [WORD_W-1:0]  instr;
      logic [WORD_W-1:0]  rn_value;
      logic [WORD_W-1:0]  rm_data;
      logic [WORD_W-1:0]  rs_data;
      logic [FLAGS_W-1:0] flags_in;
   } req_fields_type;

   typedef struct packed {
      logic [WORD_W-1:0]  result;
      logic               write_enable;
      logic [REG_W-1:0]   dest_reg;
      logic [FLAGS_W-1:0] flags_out;
      logic               flags_written;
      logic               pc_flush;
      logic               restore_psr;
   } rsp_fields_type;

   function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] n);
      logic [2*WORD_W-1:0] t;
      t = {v, v} >> n;
      return t[WORD_W-1:0];
   endfunction

   // Shift by 1..31; a rotate by 0 passes rm with carry from bit 31.
   function automatic shift_res_type shift_by(input shift_kind_type kind,
                                              input logic [WORD_W-1:0] rm,
                                              input logic [4:0] n);
      logic [2*WORD_W-1:0] t;
      shift_res_type       r;
      t = '0;
      r = '0;
      case (kind)
         SH_LSL: begin
            t       = {{WORD_W{1'b0}}, rm} << n;
            r.value = t[WORD_W-1:0];
            r.carry = t[WORD_W];
         end
         SH_LSR: begin
            t       = {rm, {WORD_W{1'b0}}} >> n;
            r.value = t[2*WORD_W-1:WORD_W];
            r.carry = t[WORD_W-1];
         end
         SH_ASR: begin
            t       = $unsigned($signed({rm, {WORD_W{1'b0}}}) >>> n);
            r.value = t[2*WORD_W-1:WORD_W];
            r.carry = t[WORD_W-1];
         end
         default: begin
            r.value = ror32(rm, n);
            r.carry = r.value[WORD_W-1];
         end
      endcase
      return r;
   endfunction

   // Operand 2 and shifter carry out.
   function automatic shift_res_type operand2_shift(input logic [WORD_W-1:0] instr,
                                                    input logic [WORD_W-1:0] rm,
                                                    input logic [WORD_W-1:0] rs,
                                                    input logic              cin);
      logic [4:0]        rot;
      logic [7:0]        amt_r;
      logic [4:0]        amt_i;
      shift_kind_type    kind;
      logic [WORD_W-1:0] fill;
      shift_res_type     r;
      rot   = {instr[11:8], 1'b0};
      amt_r = rs[7:0];
      amt_i = instr[11:7];
      kind  = shift_kind_type'(instr[6:5]);
      fill  = {WORD_W{rm[WORD_W-1]}};
      r     = '0;
      if (instr[25]) begin
         r.value = ror32({24'd0, instr[7:0]}, rot);
         r.carry = (rot == 5'd0) ? cin : r.value[WORD_W-1];
      end else if (instr[4]) begin
         if (amt_r == 8'd0) begin
            r = '{value: rm, carry: cin};
         end else if (amt_r < 8'd32 || kind == SH_ROR) begin
            r = shift_by(kind, rm, amt_r[4:0]);
         end else begin
            case (kind)
               SH_LSL:  r = '{value: '0, carry: (amt_r == 8'd32) & rm[0]};
               SH_LSR:  r = '{value: '0, carry: (amt_r == 8'd32) & rm[WORD_W-1]};
               default: r = '{value: fill, carry: rm[WORD_W-1]};
            endcase
         end
      end else if (amt_i != 5'd0) begin
         r = shift_by(kind, rm, amt_i);
      end else begin
         // amount zero: LSL passes, LSR/ASR mean 32, ROR means RRX
         case (kind)
            SH_LSL:  r = '{value: rm, carry: cin};
            SH_LSR:  r = '{value: '0, carry: rm[WORD_W-1]};
            SH_ASR:  r = '{value: fill, carry: rm[WORD_W-1]};
            default: r = '{value: {cin, rm[WORD_W-1:1]}, carry: rm[0]};
         endcase
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/arm_data_processing_alu.sv
// ----------------------------------------------------------------------------
// ARM data-processing ALU
// Barrel shifter, sixteen-opcode ALU and flag logic for one ARM
// data-processing instruction per transfer.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (tdata, lowest bit first)
// req_*     in   instr[31:0] rn_value[63:32] rm_data[95:64] rs_data[127:96]
//                flags_in[131:128], zero pad to 136
// rsp_*     out  result[31:0] write_enable[32] dest_reg[36:33] flags_out[40:37]
//                flags_written[41] pc_flush[42] restore_psr[43], zero pad to 48
//
// One transfer in per cycle, one transfer out per cycle, while rsp_tready stays high.
// Each transfer goes through the input register, then one shifter + adder pass into
// the result register.
// Synchronous active-high reset clears both valid bits; payloads are not reset.
// A stall on rsp_tready holds the result register, then the input register,
// and drops req_tready only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_data_processing_alu
   import adpalu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // instr, rn_value, rm_data, rs_data, flags_in, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // result, write_enable, dest_reg, flags_out, flags_written, pc_flush,
   // restore_psr, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Pipeline control
   logic           req_valid_ff, req_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_open;    // result register can take a new value
   logic           req_open;    // input register can take a new transfer

   // Payload registers
   req_fields_type req_ff, req_in;
   rsp_fields_type rsp_ff, rsp_in;

   // Execute-stage signals
   opcode_type        opcode;
   shift_res_type     shift;
   logic [WORD_W-1:0] op1, op2;
   logic [WORD_W-1:0] add_a, add_b;
   logic              add_c;
   logic [WORD_W:0]   add_sum;
   logic              add_v;
   logic              logical;
   logic              cin;
   logic              s_bit;
   logic [REG_W-1:0]  rd;

   // Advance the result register when empty or taken; advance the input
   // register when empty or when its content moves on.
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign req_open   = !req_valid_ff || rsp_open;
   assign req_tready = req_open;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (req_open) begin
         req_valid_in = req_tvalid;
      end
      if (req_open && req_tvalid) begin
         req_in.instr    = req_tdata[WORD_W-1:0];
         req_in.rn_value = req_tdata[2*WORD_W-1:WORD_W];
         req_in.rm_data  = req_tdata[3*WORD_W-1:2*WORD_W];
         req_in.rs_data  = req_tdata[4*WORD_W-1:3*WORD_W];
         req_in.flags_in = req_tdata[4*WORD_W+FLAGS_W-1:4*WORD_W];
      end
   end

   // Decode and operand 2
   always_comb begin
      opcode = opcode_type'(req_ff.instr[24:21]);
      rd     = req_ff.instr[15:12];
      s_bit  = req_ff.instr[20];
      cin    = req_ff.flags_in[1];
      op1    = req_ff.rn_value;
      shift  = operand2_shift(req_ff.instr, req_ff.rm_data, req_ff.rs_data, cin);
      op2    = shift.value;
   end

   // One shared adder: pick operands and carry-in per opcode
   always_comb begin
      add_a   = op1;
      add_b   = op2;
      add_c   = 1'b0;
      logical = 1'b0;
      case (opcode)
         OP_SUB, OP_CMP: begin
            add_b = ~op2;
            add_c = 1'b1;
         end
         OP_RSB: begin
            add_a = op2;
            add_b = ~op1;
            add_c = 1'b1;
         end
         OP_ADD, OP_CMN: begin
            add_c = 1'b0;
         end
         OP_ADC: begin
            add_c = cin;
         end
         OP_SBC: begin
            add_b = ~op2;
            add_c = cin;
         end
         OP_RSC: begin
            add_a = op2;
            add_b = ~op1;
            add_c = cin;
         end
         default: begin
            logical = 1'b1;
         end
      endcase
      add_sum = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_c};
      add_v   = ~(add_a[WORD_W-1] ^ add_b[WORD_W-1]) &
                (add_a[WORD_W-1] ^ add_sum[WORD_W-1]);
   end

   // Result, flags and write-back controls
   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_open && req_valid_ff) begin
         case (opcode)
            OP_AND, OP_TST: rsp_in.result = op1 & op2;
            OP_EOR, OP_TEQ: rsp_in.result = op1 ^ op2;
            OP_ORR:         rsp_in.result = op1 | op2;
            OP_MOV:         rsp_in.result = op2;
            OP_BIC:         rsp_in.result = op1 & ~op2;
            OP_MVN:         rsp_in.result = ~op2;
            default:        rsp_in.result = add_sum[WORD_W-1:0];
         endcase
         rsp_in.write_enable  = !(opcode inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
         rsp_in.dest_reg      = rd;
         rsp_in.flags_written = s_bit;
         rsp_in.flags_out     = req_ff.flags_in;
         if (s_bit) begin
            // N and Z from the result; logical ops: C from the shifter, keep V; else C and V from the adder
            rsp_in.flags_out[3] = rsp_in.result[WORD_W-1];
            rsp_in.flags_out[2] = (rsp_in.result == '0);
            rsp_in.flags_out[1] = logical ? shift.carry : add_sum[WORD_W];
            rsp_in.flags_out[0] = logical ? req_ff.flags_in[0] : add_v;
         end
         rsp_in.pc_flush    = (rd == PC_REG) && rsp_in.write_enable;
         rsp_in.restore_psr = (rd == PC_REG) && s_bit;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_open) begin
         rsp_valid_in = req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}},
                        rsp_ff.restore_psr, rsp_ff.pc_flush, rsp_ff.flags_written,
                        rsp_ff.flags_out, rsp_ff.dest_reg, rsp_ff.write_enable,
                        rsp_ff.result};

endmodule

// File: hw/rtl/adpalu_checker.sv
// ----------------------------------------------------------------------------
// ARM data-processing ALU checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_data_processing_alu_assert.svh"

module adpalu_checker
   import adpalu_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic             we;
   logic [REG_W-1:0] dest;
   logic             fw;
   logic             flush;
   logic             restore;

   assign we      = rsp_tdata[WORD_W];
   assign dest    = rsp_tdata[WORD_W+REG_W:WORD_W+1];
   assign fw      = rsp_tdata[WORD_W+REG_W+FLAGS_W+1];
   assign flush   = rsp_tdata[WORD_W+REG_W+FLAGS_W+2];
   assign restore = rsp_tdata[WORD_W+REG_W+FLAGS_W+3];

   // Hold a stalled result
   `ADPALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp transfer changed while stalled")
   // No result in the cycle after reset
   `ADPALU_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid, "rsp_tvalid high after reset")
   // PC flush only for a write to R15
   `ADPALU_ASSERT_NOW(a_flush, clock, reset, rsp_tvalid, flush == (we && dest == PC_REG), "pc_flush disagrees with write_enable and dest_reg")
   // PSR restore only for R15 with S set
   `ADPALU_ASSERT_NOW(a_restore, clock, reset, rsp_tvalid, restore == (fw && dest == PC_REG), "restore_psr disagrees with flags_written and dest_reg")

endmodule

bind arm_data_processing_alu adpalu_checker u_adpalu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/sv/arm_data_processing_alu_tb.sv
// ----------------------------------------------------------------------------
// ARM data-processing ALU testbench
// Streams data-processing instructions with register values and flags into
// the ALU. A scoreboard predicts operand 2, the result, the flags and the
// PC/PSR controls for every accepted transfer, then compares each result
// transfer field by field, in order. Both sides stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_data_processing_alu_tb
   import adpalu_pkg::*;
();

   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned RANDOM_ITEMS = 1250;

   // Predicts one result per instruction and checks results in order.
   class dp_result_checker;
      rsp_fields_type outcomes[$];
      int unsigned    mismatch_count = 0;

      // Print one line and count it.
      task report(string msg);
         mismatch_count++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      // Operand 2 with the shifter carry on top: {carry, value}.
      function logic [32:0] shift_operand(logic [31:0] instr, logic [31:0] rm,
                                          logic [31:0] rs, logic cin);
         int             n;
         logic [31:0]    imm;
         logic [31:0]    sign_fill;
         shift_kind_type kind;
         kind      = shift_kind_type'(instr[6:5]);
         sign_fill = {32{rm[31]}};
         if (instr[25]) begin
            imm = {24'd0, instr[7:0]};
            n   = 2 * instr[11:8];
            if (n == 0) return {cin, imm};
            imm = (imm >> n) | (imm << (32 - n));
            return {imm[31], imm};
         end
         if (instr[4]) begin
            n = rs[7:0];
            if (n == 0) return {cin, rm};
            if (n >= 32) begin
               case (kind)
                  SH_LSL: return {(n == 32) && rm[0], 32'd0};
                  SH_LSR: return {(n == 32) && rm[31], 32'd0};
                  SH_ASR: return {rm[31], sign_fill};
                  default: begin
                     if (n % 32 == 0) return {rm[31], rm};
                     n = n % 32;
                  end
               endcase
            end
         end else begin
            n = instr[11:7];
            if (n == 0) begin
               case (kind)
                  SH_LSL:  return {cin, rm};
                  SH_LSR:  return {rm[31], 32'd0};
                  SH_ASR:  return {rm[31], sign_fill};
                  default: return {rm[0], cin, rm[31:1]};
               endcase
            end
         end
         // plain shift by 1..31
         case (kind)
            SH_LSL:  return {rm[32 - n], rm << n};
            SH_LSR:  return {rm[n - 1], rm >> n};
            SH_ASR:  return {rm[n - 1], (rm >> n) | (sign_fill << (32 - n))};
            default: return {rm[n - 1], (rm >> n) | (rm << (32 - n))};
         endcase
      endfunction

      // a + b + c as {overflow, carry, sum}.
      function logic [33:0] add_with_flags(logic [31:0] a, logic [31:0] b, logic c);
         logic [32:0] sum;
         logic        ovf;
         sum = {1'b0, a} + {1'b0, b} + {32'd0, c};
         ovf = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
         return {ovf, sum};
      endfunction

      function rsp_fields_type execute_dp(req_fields_type item);
         rsp_fields_type r;
         opcode_type     op;
         logic [31:0]    op2;
         logic [31:0]    rn;
         logic           sh_carry;
         logic           add_carry;
         logic           add_ovf;
         logic           cin;
         logic           setf;
         logic           logical;
         cin       = item.flags_in[1];
         rn        = item.rn_value;
         op        = opcode_type'(item.instr[24:21]);
         setf      = item.instr[20];
         logical   = 1'b1;
         add_carry = 1'b0;
         add_ovf   = 1'b0;
         {sh_carry, op2} = shift_operand(item.instr, item.rm_data, item.rs_data, cin);
         r = '0;
         case (op)
            OP_AND, OP_TST: r.result = rn & op2;
            OP_EOR, OP_TEQ: r.result = rn ^ op2;
            OP_ORR:         r.result = rn | op2;
            OP_MOV:         r.result = op2;
            OP_BIC:         r.result = rn & ~op2;
            OP_MVN:         r.result = ~op2;
            default: begin
               logical = 1'b0;
               case (op)
                  OP_SUB, OP_CMP:
                     {add_ovf, add_carry, r.result} = add_with_flags(rn, ~op2, 1'b1);
                  OP_RSB:
                     {add_ovf, add_carry, r.result} = add_with_flags(op2, ~rn, 1'b1);
                  OP_ADD, OP_CMN:
                     {add_ovf, add_carry, r.result} = add_with_flags(rn, op2, 1'b0);
                  OP_ADC:
                     {add_ovf, add_carry, r.result} = add_with_flags(rn, op2, cin);
                  OP_SBC:
                     {add_ovf, add_carry, r.result} = add_with_flags(rn, ~op2, cin);
                  default:
                     {add_ovf, add_carry, r.result} = add_with_flags(op2, ~rn, cin);
               endcase
            end
         endcase
         r.write_enable  = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
         r.dest_reg      = item.instr[15:12];
         r.flags_written = setf;
         if (!setf)
            r.flags_out = item.flags_in;
         else if (logical)
            r.flags_out = {r.result[31], r.result == 32'd0, sh_carry, item.flags_in[0]};
         else
            r.flags_out = {r.result[31], r.result == 32'd0, add_carry, add_ovf};
         r.pc_flush    = (r.dest_reg == PC_REG) && r.write_enable;
         r.restore_psr = (r.dest_reg == PC_REG) && setf;
         return r;
      endfunction

      function void note_request(req_fields_type item);
         outcomes.push_back(execute_dp(item));
      endfunction

      task check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] tdata);
         rsp_fields_type want;
         if (outcomes.size() == 0) begin
            report($sformatf("result transfer with nothing pending, tdata 0x%0h", tdata));
            return;
         end
         want = outcomes.pop_front();
         check_field("result",        tdata[31:0],       want.result);
         check_field("write_enable",  32'(tdata[32]),    32'(want.write_enable));
         check_field("dest_reg",      32'(tdata[36:33]), 32'(want.dest_reg));
         check_field("flags_out",     32'(tdata[40:37]), 32'(want.flags_out));
         check_field("flags_written", 32'(tdata[41]),    32'(want.flags_written));
         check_field("pc_flush",      32'(tdata[42]),    32'(want.pc_flush));
         check_field("restore_psr",   32'(tdata[43]),    32'(want.restore_psr));
      endtask

      function int unsigned pending();
         return outcomes.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // instr, rn_value, rm_data, rs_data, flags_in, zero pad
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // result, write_enable, dest_reg, flags_out, flags_written, pc_flush,
   // restore_psr, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   dp_result_checker board = new();
   logic             steady_phase = 1'b0;  // high: neither side idles
   int unsigned      quiet_cycles = 0;

   arm_data_processing_alu dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Stall the result side about 15 percent of the time, except in the steady phase.
   always @(negedge clock) begin
      rsp_tready <= steady_phase ? 1'b1 : ($urandom_range(0, 99) >= 15);
   end

   // Check every result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one instruction; return at the falling edge after its transfer.
   task automatic send(logic [31:0] instr, logic [31:0] rn, logic [31:0] rm,
                       logic [31:0] rs, logic [3:0] flags);
      req_fields_type item;
      item = '{instr: instr, rn_value: rn, rm_data: rm, rs_data: rs, flags_in: flags};
      // insert random gaps before the transfer
      while (!steady_phase && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({item.flags_in, item.rs_data, item.rm_data,
                                  item.rn_value, item.instr});
      do @(posedge clock); while (!req_tready);
      board.note_request(item);
      @(negedge clock);
   endtask

   // Hold the request side until every predicted result has arrived.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   // Data-processing word with a random condition and Rn number.
   function automatic logic [31:0] dp_word(opcode_type op, logic imm, logic setf,
                                           logic [3:0] rd, logic [11:0] op2);
      logic [3:0] cond;
      logic [3:0] rn_no;
      cond  = 4'($urandom);
      rn_no = 4'($urandom);
      return {cond, 2'b00, imm, op, setf, rn_no, rd, op2};
   endfunction

   function automatic logic [11:0] imm_shift_field(logic [4:0] amt, shift_kind_type kind);
      logic [3:0] rm_no;
      rm_no = 4'($urandom);
      return {amt, kind, 1'b0, rm_no};
   endfunction

   function automatic logic [11:0] reg_shift_field(shift_kind_type kind);
      logic [3:0] rs_no;
      logic [3:0] rm_no;
      rs_no = 4'($urandom);
      rm_no = 4'($urandom);
      return {rs_no, 1'b0, kind, 1'b1, rm_no};
   endfunction

   // Favor the edges of the 32-bit range.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         4:       return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Shift register value: low byte zero, 32, multiples of 32, over 32 or 1..31.
   function automatic logic [31:0] pick_shift_reg();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0:       v[7:0] = 8'd0;
         1:       v[7:0] = 8'd32;
         2:       v[7:0] = {3'($urandom_range(1, 7)), 5'd0};
         3:       v[7:0] = 8'($urandom_range(33, 255));
         default: v[7:0] = 8'($urandom_range(1, 31));
      endcase
      return v;
   endfunction

   function automatic logic [31:0] random_instr();
      opcode_type     op;
      shift_kind_type kind;
      logic [3:0]     rd;
      logic [4:0]     amt;
      logic [11:0]    op2;
      logic [31:0]    w;
      logic           imm;
      // noise: any word at all
      if ($urandom_range(0, 7) == 0) return $urandom;
      op   = opcode_type'($urandom_range(0, 15));
      kind = shift_kind_type'($urandom_range(0, 3));
      rd   = ($urandom_range(0, 7) == 0) ? PC_REG : 4'($urandom);
      imm  = ($urandom_range(0, 3) == 0);
      amt  = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
      if (imm)
         op2 = 12'($urandom);
      else if ($urandom_range(0, 1) == 0)
         op2 = reg_shift_field(kind) | {4'd0, 1'($urandom), 7'd0};
      else
         op2 = imm_shift_field(amt, kind);
      w = dp_word(op, imm, 1'($urandom), rd, op2);
      if ($urandom_range(0, 15) == 0) w[27:26] = 2'($urandom);
      return w;
   endfunction

   initial begin
      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every opcode, shifter edge cases, R15 destinations
      send(dp_word(OP_AND, 1'b1, 1'b1, 4'h1, {4'h0, 8'hff}), 32'hffff_ffff, 0, 0, 4'b0010);
      send(dp_word(OP_EOR, 1'b1, 1'b1, 4'h2, {4'h1, 8'h03}), 0, 0, 0, 4'b0000);
      send(dp_word(OP_SUB, 1'b0, 1'b1, 4'h3, imm_shift_field(5'd0, SH_LSL)),
           0, 1, 0, 4'b0010);
      send(dp_word(OP_RSB, 1'b0, 1'b1, 4'h4, imm_shift_field(5'd0, SH_LSR)),
           5, 32'h8000_0000, 0, 4'b0001);
      send(dp_word(OP_ADD, 1'b0, 1'b1, 4'h5, imm_shift_field(5'd0, SH_ASR)),
           32'h7fff_ffff, 32'h8000_0001, 0, 4'b0000);
      send(dp_word(OP_ADC, 1'b0, 1'b1, 4'h6, imm_shift_field(5'd0, SH_ROR)),
           1, 3, 0, 4'b0010);
      send(dp_word(OP_SBC, 1'b0, 1'b1, 4'h7, reg_shift_field(SH_ROR)),
           10, 3, 32'h0000_0100, 4'b0000);
      send(dp_word(OP_RSC, 1'b0, 1'b1, 4'h8, reg_shift_field(SH_LSL)), 0, 1, 32, 4'b0010);
      send(dp_word(OP_TST, 1'b0, 1'b1, PC_REG, reg_shift_field(SH_LSR)),
           32'hffff_ffff, 32'h8000_0000, 32, 4'b0000);
      send(dp_word(OP_TEQ, 1'b0, 1'b1, 4'h9, reg_shift_field(SH_LSL)),
           0, 32'hffff_ffff, 33, 4'b0011);
      send(dp_word(OP_CMP, 1'b0, 1'b1, 4'ha, reg_shift_field(SH_LSR)),
           32'h8000_0000, 32'hffff_ffff, 40, 4'b0010);
      send(dp_word(OP_CMN, 1'b0, 1'b1, 4'hb, reg_shift_field(SH_ASR)),
           32'hffff_ffff, 32'h8000_0000, 32, 4'b0000);
      send(dp_word(OP_ORR, 1'b0, 1'b1, 4'hc, reg_shift_field(SH_ASR)),
           0, 32'h7fff_ffff, 200, 4'b1111);
      send(dp_word(OP_MOV, 1'b0, 1'b1, 4'hd, reg_shift_field(SH_ROR)),
           0, 32'h8000_0001, 64, 4'b0000);
      send(dp_word(OP_BIC, 1'b0, 1'b1, 4'he, reg_shift_field(SH_ROR)),
           32'hffff_ffff, 32'h0000_0031, 37, 4'b0000);
      send(dp_word(OP_MVN, 1'b1, 1'b1, PC_REG, {4'hf, 8'hff}), 0, 0, 0, 4'b0101);
      send(dp_word(OP_MOV, 1'b1, 1'b0, PC_REG, {4'h4, 8'h81}), 0, 0, 0, 4'b1010);
      send(dp_word(OP_ADD, 1'b0, 1'b1, 4'h0, imm_shift_field(5'd0, SH_LSL)),
           32'h7fff_ffff, 1, 0, 4'b0000);
      send(dp_word(OP_ADD, 1'b0, 1'b1, 4'h1, imm_shift_field(5'd31, SH_LSL)),
           32'hffff_ffff, 3, 0, 4'b0000);
      send(dp_word(OP_SUB, 1'b0, 1'b1, 4'h2, imm_shift_field(5'd31, SH_ASR)),
           0, 32'h8000_0000, 0, 4'b0000);
      send(dp_word(OP_RSC, 1'b0, 1'b1, 4'h3, imm_shift_field(5'd1, SH_ROR)),
           0, 1, 0, 4'b0000);
      // bits 27:26 set, bit 7 set in a register shift
      send(dp_word(OP_EOR, 1'b0, 1'b1, 4'h4, reg_shift_field(SH_LSR)) | 32'h0c00_0080,
           32'h1234_5678, 32'hf000_000f, 32'hffff_ff05, 4'b0110);
      send(dp_word(OP_ADD, 1'b0, 1'b1, 4'h5, imm_shift_field(5'd0, SH_LSL)),
           0, 0, 0, 4'b1101);
      send(dp_word(OP_SBC, 1'b0, 1'b1, 4'h6, imm_shift_field(5'd0, SH_LSL)),
           0, 0, 0, 4'b0010);
      send(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 4'hf);

      // let every directed result come back before the random stream
      drain();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady_phase <= (i >= 500 && i < 750);
         if (i == 900) drain();
         send(random_instr(), pick_word(), pick_word(), pick_shift_reg(), 4'($urandom));
      end

      // wait for the tail, then watch for anything stray
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: arm_data_processing_alu.f
+incdir+hw/rtl
hw/rtl/adpalu_pkg.sv
hw/rtl/arm_data_processing_alu.sv
hw/rtl/adpalu_checker.sv
tb/sv/arm_data_processing_alu_tb.sv
